### rtl/rpa_pkg.sv
// Shared types and constants for the RGB point adjust block.
package rpa_pkg;

  // Operating modes held in the mode register.
  typedef enum logic [1:0] {
    MODE_OFFSET   = 2'd0,
    MODE_CONTRAST = 2'd1,
    MODE_NEGATE   = 2'd2
  } op_mode_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_OP_MODE        = 3'd0;
  localparam logic [2:0] REG_OFFSET_RED     = 3'd1;
  localparam logic [2:0] REG_OFFSET_GREEN   = 3'd2;
  localparam logic [2:0] REG_OFFSET_BLUE    = 3'd3;
  localparam logic [2:0] REG_CONTRAST_LEVEL = 3'd4;

  // Channel full scale, and the divisor 255^2 with its rounding half.
  localparam int CHAN_MAX     = 255;
  localparam int GAIN_DIVISOR = 65025;
  localparam int GAIN_ROUND   = 32512;

endpackage

### rtl/rgb_point_adjust.sv
// RGB point adjust top level: offset, contrast and negative per pixel.
// A pixel passes through the input register, then the result register.
// Throughput: one pixel per cycle while the result side is not stalled, except
// after a contrast level write: the gain is then derived by a series reciprocal,
// during which no pixel or configuration request is taken.
// Reset (synchronous, rst high): control registers clear to zero, gain to unity.
module rgb_point_adjust #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [8:0] cfg_data,
  input  logic       pix_valid,
  output logic       pix_ready,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out
);

  // Gain width (Q3.F), dividend, term product, quotient, limit and product widths.
  localparam int GW = GAIN_FRAC_BITS + 3;
  localparam int DW = GAIN_FRAC_BITS + 19;
  localparam int TW = DW + 9;
  localparam int QW = GW + 1;
  localparam int LW = GW + 17;
  localparam int PW = GW + 11;
  localparam int GAIN_TERMS = 4;
  localparam logic [GW-1:0] GAIN_UNITY = GW'(1) << GAIN_FRAC_BITS;

  // Configuration registers.
  rpa_pkg::op_mode_t op_mode;
  logic signed [8:0] offset_red;
  logic signed [8:0] offset_green;
  logic signed [8:0] offset_blue;
  logic [GW-1:0]     contrast_gain;

  // Gain derivation state.
  logic          busy;
  logic [2:0]    gain_step;
  logic [DW-1:0] gain_dividend;
  logic [DW-1:0] gain_term;
  logic [DW-1:0] gain_sum;
  logic [GW-1:0] gain_quot;
  logic [LW-1:0] gain_limit;

  // Pipeline stage registers.
  logic       s1_valid;
  logic [7:0] s1_red;
  logic [7:0] s1_green;
  logic [7:0] s1_blue;

  logic cfg_write;
  logic pix_take;
  logic res_free;
  logic s1_ready;

  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign res_free  = !res_valid || res_ready;
  assign s1_ready  = !s1_valid || res_free;
  assign pix_ready = s1_ready && !busy;
  assign pix_take  = pix_valid && pix_ready;

  // Squared base for the gain, (255 + L)^2, from the written level.
  logic signed [9:0]  level_base;
  logic signed [19:0] level_sq;
  logic [DW-1:0]      dividend_start;

  assign level_base     = 10'sd255 + 10'($signed(cfg_data));
  assign level_sq       = level_base * level_base;
  assign dividend_start = (DW'(level_sq[17:0]) << GAIN_FRAC_BITS)
                          + DW'(rpa_pkg::GAIN_ROUND);

  // Division by 255^2 as a series: 1/65025 = 2^-16 * (1 + e + e^2 + ...) with
  // e = 511 / 2^16. Each term is the previous one times e, floored, so the
  // estimate never exceeds the true quotient and falls short by at most one.
  logic [TW-1:0] term_mul;
  logic [DW-1:0] term_next;
  logic [DW-1:0] sum_next;
  logic [GW-1:0] quot_est;
  logic [QW-1:0] quot_inc;
  logic [LW-1:0] limit_next;

  always_comb begin
    term_mul   = {gain_term, 9'b0} - TW'(gain_term);
    term_next  = {7'b0, term_mul[TW-1:16]};
    sum_next   = gain_sum + term_next;
    quot_est   = gain_sum[GW+15:16];
    quot_inc   = {1'b0, quot_est} + QW'(1);
    // The limit (q + 1) * 65025 uses 65025 = 2^16 - 2^9 + 1.
    limit_next = {quot_inc, 16'b0} - LW'({quot_inc, 9'b0}) + LW'(quot_inc);
  end

  // Configuration registers and the gain derivation.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode       <= rpa_pkg::MODE_OFFSET;
      offset_red    <= '0;
      offset_green  <= '0;
      offset_blue   <= '0;
      contrast_gain <= GAIN_UNITY;
      busy          <= 1'b0;
      gain_step     <= '0;
      gain_dividend <= '0;
      gain_term     <= '0;
      gain_sum      <= '0;
      gain_quot     <= '0;
      gain_limit    <= '0;
    end else if (busy) begin
      if (gain_step < 3'(GAIN_TERMS)) begin
        gain_term <= term_next;
        gain_sum  <= sum_next;
        gain_step <= gain_step + 3'd1;
      end else if (gain_step == 3'(GAIN_TERMS)) begin
        gain_quot  <= quot_est;
        gain_limit <= limit_next;
        gain_step  <= gain_step + 3'd1;
      end else begin
        // One correction step brings the estimate to the exact quotient.
        contrast_gain <= (LW'(gain_dividend) >= gain_limit) ? gain_quot + GW'(1)
                                                            : gain_quot;
        busy          <= 1'b0;
        gain_step     <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        rpa_pkg::REG_OP_MODE:      op_mode <= rpa_pkg::op_mode_t'(cfg_data[1:0]);
        rpa_pkg::REG_OFFSET_RED:   offset_red <= $signed(cfg_data);
        rpa_pkg::REG_OFFSET_GREEN: offset_green <= $signed(cfg_data);
        rpa_pkg::REG_OFFSET_BLUE:  offset_blue <= $signed(cfg_data);
        rpa_pkg::REG_CONTRAST_LEVEL: begin
          busy          <= 1'b1;
          gain_step     <= '0;
          gain_dividend <= dividend_start;
          gain_term     <= dividend_start;
          gain_sum      <= dividend_start;
        end
        default: ;
      endcase
    end
  end

  // Offset channel: add the signed offset and saturate.
  function automatic logic [7:0] offset_chan(input logic [7:0] p,
                                             input logic signed [8:0] off);
    logic signed [9:0] sum;
    sum = $signed({2'b00, p}) + 10'(off);
    if (sum < 0) begin
      offset_chan = 8'd0;
    end else if (sum > 10'sd255) begin
      offset_chan = 8'(rpa_pkg::CHAN_MAX);
    end else begin
      offset_chan = sum[7:0];
    end
  endfunction

  // Contrast channel: scale about mid-grey by the gain and saturate.
  function automatic logic [7:0] contrast_chan(input logic [7:0] p,
                                               input logic [GW-1:0] gain);
    logic signed [9:0]    centred;
    logic signed [PW-1:0] num;
    logic [PW-1:0]        scaled;
    centred = $signed({1'b0, p, 1'b0}) - 10'sd255;
    num     = PW'(centred) * $signed(PW'({1'b0, gain}))
              + (PW'(rpa_pkg::CHAN_MAX) <<< GAIN_FRAC_BITS);
    scaled  = PW'(num) >> (GAIN_FRAC_BITS + 1);
    if (num < 0) begin
      contrast_chan = 8'd0;
    end else if (scaled > PW'(rpa_pkg::CHAN_MAX)) begin
      contrast_chan = 8'(rpa_pkg::CHAN_MAX);
    end else begin
      contrast_chan = scaled[7:0];
    end
  endfunction

  // Result selection by mode.
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  always_comb begin
    case (op_mode)
      rpa_pkg::MODE_OFFSET: begin
        red_next   = offset_chan(s1_red, offset_red);
        green_next = offset_chan(s1_green, offset_green);
        blue_next  = offset_chan(s1_blue, offset_blue);
      end
      rpa_pkg::MODE_CONTRAST: begin
        red_next   = contrast_chan(s1_red, contrast_gain);
        green_next = contrast_chan(s1_green, contrast_gain);
        blue_next  = contrast_chan(s1_blue, contrast_gain);
      end
      rpa_pkg::MODE_NEGATE: begin
        red_next   = ~s1_red;
        green_next = ~s1_green;
        blue_next  = ~s1_blue;
      end
      default: begin
        red_next   = s1_red;
        green_next = s1_green;
        blue_next  = s1_blue;
      end
    endcase
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pix_take;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take) begin
      s1_red   <= red_in;
      s1_green <= green_in;
      s1_blue  <= blue_in;
    end
  end

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && s1_valid) begin
      red_out   <= red_next;
      green_out <= green_next;
      blue_out  <= blue_next;
    end
  end

  // No pixel request is taken while the gain is being derived.
  assert property (@(posedge clk) disable iff (rst) busy |-> !pix_ready)
    else $error("pixel accepted while gain derivation busy");

  // The derivation starts only on a contrast level write.
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(cfg_write && cfg_index == rpa_pkg::REG_CONTRAST_LEVEL))
    else $error("gain derivation started without a contrast level write");

  // The step counter rests at zero whenever the derivation is idle.
  assert property (@(posedge clk) disable iff (rst) !busy |-> gain_step == '0)
    else $error("gain step counter not cleared when idle");

  // Reset leaves the gain at unity.
  assert property (@(posedge clk) $past(rst) |-> contrast_gain == GAIN_UNITY)
    else $error("gain not unity after reset");

endmodule

### verif/rgb_point_adjust_tb.sv
// Self-checking testbench for the RGB point adjust block: offset, contrast and negative modes.
module rgb_point_adjust_tb;

  localparam int GAIN_FRAC = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE_FIRST = rpa_pkg::REG_CONTRAST_LEVEL + 3'd1;
  localparam logic [2:0] REG_SPARE_LAST = 3'd7;
  localparam logic [8:0] LEVEL_MOST_NEG = 9'h100;
  localparam logic [8:0] LEVEL_NEG_FULL = 9'h101;
  localparam logic [8:0] LEVEL_POS_FULL = 9'h0FF;
  localparam int RANDOM_PIXELS = 2000;
  localparam int HOLD_PHASE = 4;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_FIRST = 10;
  localparam int QUIET_LAST = 14;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One row of the directed sequence: a register write or a pixel.
  typedef struct packed {
    logic       is_cfg;
    logic [2:0] idx;
    logic [8:0] data;
    rgb_t       pix;
    logic       known;
    rgb_t       want;
  } step_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [8:0] cfg_data;
  logic       pix_valid;
  logic       pix_ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       res_valid;
  logic       res_ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   mismatch_count = 0;
  int   cycle_count = 0;

  // Shadow copy of the block's registers and derived gain.
  logic [1:0]        mode_q;
  logic signed [8:0] ofs_red;
  logic signed [8:0] ofs_green;
  logic signed [8:0] ofs_blue;
  longint            gain_q;

  rgb_t  pending_pixels[$];
  step_t directed_steps[$];

  rgb_point_adjust #(
    .GAIN_FRAC_BITS(GAIN_FRAC)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .red_out(red_out),
    .green_out(green_out),
    .blue_out(blue_out)
  );

  always #1 clk = ~clk;

  // Squared contrast gain in fixed point, rounded to nearest.
  function automatic longint gain_for_level(logic signed [8:0] level);
    longint base;
    base = longint'(rpa_pkg::CHAN_MAX) + longint'(level);
    return (((base * base) <<< GAIN_FRAC) + rpa_pkg::GAIN_ROUND) / rpa_pkg::GAIN_DIVISOR;
  endfunction

  function automatic logic [7:0] clamp_chan(longint v);
    if (v < 0) return 8'd0;
    if (v > rpa_pkg::CHAN_MAX) return 8'(rpa_pkg::CHAN_MAX);
    return v[7:0];
  endfunction

  // Scale one channel about mid-grey; a negative numerator gives black.
  function automatic logic [7:0] contrast_chan(logic [7:0] p);
    longint centred;
    longint num;
    centred = 2 * longint'(p) - rpa_pkg::CHAN_MAX;
    num = centred * gain_q + (longint'(rpa_pkg::CHAN_MAX) <<< GAIN_FRAC);
    if (num < 0) return 8'd0;
    return clamp_chan(num >>> (GAIN_FRAC + 1));
  endfunction

  function automatic rgb_t adjust_pixel(rgb_t p);
    rgb_t q;
    case (mode_q)
      rpa_pkg::MODE_OFFSET: begin
        q.red   = clamp_chan(longint'(p.red) + longint'(ofs_red));
        q.green = clamp_chan(longint'(p.green) + longint'(ofs_green));
        q.blue  = clamp_chan(longint'(p.blue) + longint'(ofs_blue));
      end
      rpa_pkg::MODE_CONTRAST: begin
        q.red   = contrast_chan(p.red);
        q.green = contrast_chan(p.green);
        q.blue  = contrast_chan(p.blue);
      end
      rpa_pkg::MODE_NEGATE: begin
        q.red   = 8'(rpa_pkg::CHAN_MAX) - p.red;
        q.green = 8'(rpa_pkg::CHAN_MAX) - p.green;
        q.blue  = 8'(rpa_pkg::CHAN_MAX) - p.blue;
      end
      default: q = p;
    endcase
    return q;
  endfunction

  function automatic step_t cfg_row(logic [2:0] idx, logic [8:0] data);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t pix_row(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    step_t s;
    s = '0;
    s.pix = '{r, g, b};
    return s;
  endfunction

  function automatic step_t pix_known(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] er, logic [7:0] eg, logic [7:0] eb);
    step_t s;
    s = pix_row(r, g, b);
    s.known = 1'b1;
    s.want = '{er, eg, eb};
    return s;
  endfunction

  // Channel value biased toward the ends of the range.
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'(rpa_pkg::CHAN_MAX);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Signed 9-bit register value biased toward its extremes.
  function automatic logic [8:0] rand_signed9();
    case ($urandom_range(7))
      0: return LEVEL_MOST_NEG;
      1: return LEVEL_NEG_FULL;
      2: return LEVEL_POS_FULL;
      3: return 9'd0;
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  // Register write, issued only once every pending pixel has come back.
  // Valid is left high so that back-to-back writes need no gap.
  task automatic write_reg(logic [2:0] idx, logic [8:0] data);
    pix_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rpa_pkg::REG_OP_MODE:        mode_q = data[1:0];
      rpa_pkg::REG_OFFSET_RED:     ofs_red = data;
      rpa_pkg::REG_OFFSET_GREEN:   ofs_green = data;
      rpa_pkg::REG_OFFSET_BLUE:    ofs_blue = data;
      rpa_pkg::REG_CONTRAST_LEVEL: gain_q = gain_for_level(data);
      default: ;
    endcase
  endtask

  // Offer one pixel request and record its expected result on acceptance.
  task automatic send_pixel(rgb_t p, logic known, rgb_t want);
    cfg_valid <= 1'b0;
    pix_valid <= 1'b1;
    red_in <= p.red;
    green_in <= p.green;
    blue_in <= p.blue;
    do @(posedge clk); while (!pix_ready);
    pending_pixels.push_back(known ? want : adjust_pixel(p));
  endtask

  task automatic pixel_gap();
    if (!quiet && $urandom_range(99) < 7) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic check_chan(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: random stalls plus one long hold-off to back up the block.
  initial begin
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= quiet || ($urandom_range(99) >= 7);
      end
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time, red_out, green_out, blue_out);
        mismatch_count++;
      end else begin
        rgb_t want;
        want = pending_pixels.pop_front();
        check_chan("red_out", want.red, red_out);
        check_chan("green_out", want.green, green_out);
        check_chan("blue_out", want.blue, blue_out);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL rgb_point_adjust");
      $finish;
    end
  end

  // Stimulus: directed rows first, then random phases of settings and pixels.
  initial begin
    step_t row;
    rgb_t  p;
    int    items_sent;
    int    phase;
    int    n;
    int    m;
    logic [1:0] mode_pick;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix_valid = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    mode_q = rpa_pkg::MODE_OFFSET;
    ofs_red = '0;
    ofs_green = '0;
    ofs_blue = '0;
    gain_q = longint'(1) <<< GAIN_FRAC;

    // Identity after reset, then offset saturation at both ends.
    directed_steps.push_back(pix_known(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    directed_steps.push_back(pix_known(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
    directed_steps.push_back(pix_known(8'h55, 8'hAA, 8'h0F, 8'h55, 8'hAA, 8'h0F));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OFFSET_RED, LEVEL_POS_FULL));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OFFSET_GREEN, LEVEL_NEG_FULL));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OFFSET_BLUE, LEVEL_MOST_NEG));
    directed_steps.push_back(pix_known(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0));
    directed_steps.push_back(pix_known(8'd0, 8'd128, 8'd255, 8'd255, 8'd0, 8'd0));
    directed_steps.push_back(pix_row(8'd1, 8'd254, 8'd128));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OFFSET_RED, 9'h1C0));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OFFSET_GREEN, 9'h040));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OFFSET_BLUE, 9'h000));
    directed_steps.push_back(pix_row(8'd100, 8'd200, 8'd30));
    // Negative and the unused mode, which passes pixels through.
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OP_MODE, 9'(rpa_pkg::MODE_NEGATE)));
    directed_steps.push_back(pix_known(8'd0, 8'd255, 8'h5A, 8'd255, 8'd0, 8'hA5));
    directed_steps.push_back(pix_row(8'h80, 8'h7F, 8'h01));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OP_MODE, 9'(MODE_UNUSED)));
    directed_steps.push_back(pix_known(8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56));
    // Contrast at unity gain, full gain, zero gain and the near-zero gain.
    directed_steps.push_back(cfg_row(rpa_pkg::REG_OP_MODE, 9'(rpa_pkg::MODE_CONTRAST)));
    directed_steps.push_back(pix_known(8'd0, 8'd128, 8'd255, 8'd0, 8'd128, 8'd255));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_CONTRAST_LEVEL, LEVEL_POS_FULL));
    directed_steps.push_back(pix_known(8'd0, 8'd255, 8'd128, 8'd0, 8'd255, 8'd129));
    directed_steps.push_back(pix_row(8'd100, 8'd150, 8'd127));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_CONTRAST_LEVEL, LEVEL_NEG_FULL));
    directed_steps.push_back(pix_known(8'd0, 8'd255, 8'd77, 8'd127, 8'd127, 8'd127));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_CONTRAST_LEVEL, LEVEL_MOST_NEG));
    directed_steps.push_back(pix_known(8'd0, 8'd255, 8'd128, 8'd127, 8'd127, 8'd127));
    // Writes to indexes past the last register change nothing.
    directed_steps.push_back(cfg_row(REG_SPARE_FIRST, 9'h1FF));
    directed_steps.push_back(cfg_row(REG_SPARE_LAST, 9'h000));
    directed_steps.push_back(pix_known(8'd0, 8'd255, 8'd1, 8'd127, 8'd127, 8'd127));
    directed_steps.push_back(cfg_row(rpa_pkg::REG_CONTRAST_LEVEL, 9'd100));
    directed_steps.push_back(pix_row(8'd10, 8'd128, 8'd240));
    directed_steps.push_back(pix_row(8'd0, 8'd255, 8'd200));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      row = directed_steps[i];
      if (row.is_cfg) begin
        write_reg(row.idx, row.data);
      end else begin
        send_pixel(row.pix, row.known, row.want);
        pixel_gap();
      end
    end

    // Random phases; each settings change waits for the pipe to drain.
    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_PIXELS) begin
      quiet <= (phase >= QUIET_FIRST) && (phase <= QUIET_LAST);
      m = $urandom_range(9);
      mode_pick = (m < 4) ? rpa_pkg::MODE_OFFSET :
                  (m < 8) ? rpa_pkg::MODE_CONTRAST :
                  (m < 9) ? rpa_pkg::MODE_NEGATE : MODE_UNUSED;
      if (phase == 0 || $urandom_range(99) < 60)
        write_reg(rpa_pkg::REG_OP_MODE, {7'($urandom_range(127)), mode_pick});
      if (phase == 0 || $urandom_range(99) < 60)
        write_reg(rpa_pkg::REG_OFFSET_RED, rand_signed9());
      if (phase == 0 || $urandom_range(99) < 60)
        write_reg(rpa_pkg::REG_OFFSET_GREEN, rand_signed9());
      if (phase == 0 || $urandom_range(99) < 60)
        write_reg(rpa_pkg::REG_OFFSET_BLUE, rand_signed9());
      if (phase == 0 || $urandom_range(99) < 60)
        write_reg(rpa_pkg::REG_CONTRAST_LEVEL, rand_signed9());
      if ($urandom_range(99) < 15)
        write_reg(3'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                  9'($urandom_range(511)));
      if (phase == HOLD_PHASE)
        hold_req <= 1'b1;
      n = $urandom_range(10, 100);
      repeat (n) begin
        p = '{rand_chan(), rand_chan(), rand_chan()};
        send_pixel(p, 1'b0, '0);
        pixel_gap();
        items_sent++;
      end
      phase++;
    end

    pix_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS rgb_point_adjust");
    end else begin
      $display("FAIL rgb_point_adjust");
    end
    $finish;
  end

endmodule

### files.f
rtl/rpa_pkg.sv
rtl/rgb_point_adjust.sv
verif/rgb_point_adjust_tb.sv
